// ===== design/assert_macros.svh =====
// Assertion macros for the checker file tcw_checker.sv.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication that holds in the same cycle.
`define TCW_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcw check failed");

// Check an implication that holds in the next cycle.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

// ===== design/tcw_pkg.sv =====
// Package for the text console writer: types, opcodes, character codes, cell words.
// Used by tcw_front, tcw_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_ESC   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic [15:0] CellBlank   = 16'h0720;
  localparam logic [15:0] CellCleared = 16'h0700;
  localparam logic [7:0]  AttrDefault = 8'h07;
  localparam logic [7:0]  AttrBold    = 8'h08;
  localparam logic [7:0]  AttrHiMask  = 8'hF0;
  localparam logic [7:0]  AttrLoMask  = 8'h0F;

  typedef enum logic [3:0] {
    K_PRINT, K_BS, K_TAB, K_CR, K_LF, K_NOP, K_ESC, K_CLEAR, K_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } cmd_t;

  function automatic cmd_kind_e classify(logic [1:0] op, logic [7:0] c);
    cmd_kind_e k;
    k = K_NOP;
    case (op)
      OP_PUT: begin
        if (c == CH_BS) k = K_BS;
        else if (c == CH_TAB) k = K_TAB;
        else if (c == CH_CR) k = K_CR;
        else if (c == CH_LF) k = K_LF;
        else if (c >= CH_SPACE) k = K_PRINT;
        else k = K_NOP;
      end
      OP_ESC:   k = K_ESC;
      OP_CLEAR: k = K_CLEAR;
      default:  k = K_READ;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== design/tcw_front.sv =====
// Front end: classify incoming beats and hold them in a two-entry queue.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front import tcw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_address_i,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o,
  input  wire logic        cmd_take_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_take;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_take     = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_take ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= '{kind: classify(opcode_i, char_code_i),
                            char_code: char_code_i, cell_address: cell_address_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/tcw_back.sv =====
// Back end: cursor, attribute, escape parser, cell store and scroll/clear sequencer.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_take_o,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      read_data_o,
  output logic [10:0]      cursor_index_o,
  output logic             byte_consumed_o,
  output logic             escape_open_o
);

  localparam int unsigned Cells  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned CopyN  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int unsigned AW     = $clog2(Cells);
  localparam int unsigned CW     = $clog2(SCREEN_COLUMNS);
  localparam int unsigned NW     = CW + 1;
  localparam int unsigned CntW   = $clog2(Cells + 1);
  localparam int unsigned XW     = (AW > 11) ? AW : 11;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_FG   = 2'd2;
  localparam logic [1:0] PH_BG   = 2'd3;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CW-1:0]   col_q, col_d;
  logic [AW-1:0]   base_q, base_d;
  logic [7:0]      attr_q, attr_d;
  logic [1:0]      phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     res_data_q, res_data_d;
  logic            res_cons_q, res_cons_d;
  logic            rd_ok_q, rd_ok_d;

  logic [15:0]     mem_q [Cells];
  logic [15:0]     mem_rdata_q;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata;

  logic [NW-1:0]   nc;
  logic            nl, finish, last_row;
  logic [3:0]      digit;
  logic [CntW-1:0] src;
  logic [XW-1:0]   cur_sum;

  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i && !out_valid_q;
  assign last_row   = (base_q == AW'(CopyN));
  assign digit      = 4'(cmd_i.char_code - CH_ZERO);
  assign src        = cnt_q + CntW'(SCREEN_COLUMNS);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    base_d     = base_q;
    attr_d     = attr_q;
    phase_d    = phase_q;
    res_data_d = res_data_q;
    res_cons_d = res_cons_q;
    rd_ok_d    = rd_ok_q;
    we         = 1'b0;
    waddr      = AW'(cnt_q);
    wdata      = CellCleared;
    raddr      = AW'(src);
    finish     = 1'b0;
    nc         = {1'b0, col_q};
    nl         = 1'b0;

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        we    = 1'b1;
        waddr = AW'(cnt_q);
        wdata = CellCleared;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
          finish  = (state_q == ST_CLEAR);
        end
      end
      ST_IDLE: begin
        if (cmd_take_o) begin
          res_data_d = 16'h0000;
          res_cons_d = 1'b1;
          case (cmd_i.kind)
            K_PRINT: begin
              we    = 1'b1;
              waddr = base_q + AW'(col_q);
              wdata = {attr_q, cmd_i.char_code};
              nc    = {1'b0, col_q} + NW'(1);
            end
            K_BS:  if (col_q != '0) nc = {1'b0, col_q} - NW'(1);
            K_TAB: nc = ({1'b0, col_q} + NW'(8)) & ~NW'(7);
            K_CR:  nc = '0;
            K_LF: begin
              nc = '0;
              nl = 1'b1;
            end
            K_ESC: begin
              case (phase_q)
                PH_IDLE: begin
                  if (cmd_i.char_code == CH_LBRK) phase_d = PH_OPEN;
                  else res_cons_d = 1'b0;
                end
                PH_FG: begin
                  attr_d  = (attr_q & AttrHiMask) | {4'h0, digit};
                  phase_d = PH_OPEN;
                end
                PH_BG: begin
                  attr_d  = (attr_q & AttrLoMask) | {digit, 4'h0};
                  phase_d = PH_OPEN;
                end
                default: begin
                  case (cmd_i.char_code)
                    CH_THREE: phase_d = PH_FG;
                    CH_FOUR:  phase_d = PH_BG;
                    CH_ZERO:  attr_d  = AttrDefault;
                    CH_ONE:   attr_d  = attr_q | AttrBold;
                    CH_SEMI:  phase_d = PH_OPEN;
                    CH_M:     phase_d = PH_IDLE;
                    default: begin
                      phase_d    = PH_IDLE;
                      res_cons_d = 1'b0;
                    end
                  endcase
                end
              endcase
            end
            K_CLEAR: begin
              col_d   = '0;
              base_d  = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            K_READ: begin
              raddr   = AW'(cmd_i.cell_address);
              rd_ok_d = ({21'b0, cmd_i.cell_address} < Cells);
              state_d = ST_READ;
            end
            default: ;
          endcase
          if (cmd_i.kind == K_PRINT || cmd_i.kind == K_BS || cmd_i.kind == K_TAB ||
              cmd_i.kind == K_CR || cmd_i.kind == K_LF || cmd_i.kind == K_NOP ||
              cmd_i.kind == K_ESC) begin
            if (nc >= NW'(SCREEN_COLUMNS)) begin
              nc = '0;
              nl = 1'b1;
            end
            col_d = CW'(nc);
            if (nl && last_row) begin
              cnt_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              if (nl) base_d = base_q + AW'(SCREEN_COLUMNS);
              finish = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        res_data_d = rd_ok_q ? mem_rdata_q : 16'h0000;
        state_d    = ST_IDLE;
        finish     = 1'b1;
      end
      ST_SCROLL: begin
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - 1'b1);
          wdata = mem_rdata_q;
        end
        if (cnt_q == CntW'(CopyN)) state_d = ST_FILL;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = AW'(cnt_q);
        wdata = CellBlank;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Cells - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
          finish  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = (out_valid_q && !pop) || finish;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    mem_rdata_q <= mem_q[raddr];
    res_data_q  <= res_data_d;
    res_cons_q  <= res_cons_d;
    rd_ok_q     <= rd_ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      attr_q      <= AttrDefault;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      base_q      <= base_d;
      attr_q      <= attr_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cur_sum         = XW'(base_q) + XW'(col_q);
  assign cursor_index_o  = cur_sum[10:0];
  assign escape_open_o   = (phase_q != PH_IDLE);
  assign byte_consumed_o = res_cons_q;
  assign read_data_o     = res_data_q;
  assign empty           = !out_valid_q;

endmodule
`default_nettype wire

// ===== design/text_console_writer_with_sgr.sv =====
// Top level of the text console writer: front queue feeding the execution back end.
// Depends on tcw_pkg, tcw_front and tcw_back.
//
//   channel  | handshake    | beat fields
//   ---------+--------------+---------------------------------------------------
//   command  | push / full  | opcode_i, char_code_i, cell_address_i
//   result   | empty / pop  | read_data_o, cursor_index_o, byte_consumed_o, escape_open_o
//
// Put char without scroll and escape bytes finish in the back end's idle state; reads also pass through ST_READ.
// Scroll copies (ROWS-1)*COLUMNS cells up one row, then writes COLUMNS blank cells in the last row;
// clear writes all ROWS*COLUMNS cells: one store write port, one cell per cycle.
// After reset all ROWS*COLUMNS cells of the store are swept before the first command runs.
// The front queue holds two commands; the back end waits while a result is not popped.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_with_sgr import tcw_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = DefColumns,
  parameter int unsigned SCREEN_ROWS    = DefRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_address_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      read_data_o,
  output logic [10:0]      cursor_index_o,
  output logic             byte_consumed_o,
  output logic             escape_open_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  tcw_front u_front (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .char_code_i, .cell_address_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take)
  );

  tcw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)
  ) u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .empty, .pop, .read_data_o, .cursor_index_o, .byte_consumed_o, .escape_open_o
  );

endmodule
`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tcw_checker #(
  parameter int unsigned SCREEN_COLUMNS = 80,
  parameter int unsigned SCREEN_ROWS    = 25
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] read_data_o,
  input wire logic [10:0] cursor_index_o,
  input wire logic        byte_consumed_o,
  input wire logic        escape_open_o
);

  localparam int unsigned Cells = SCREEN_COLUMNS * SCREEN_ROWS;

  `TCW_ASSERT_NEXT(a_hold_beat, !empty && !pop, !empty)
  `TCW_ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(read_data_o) && $stable(byte_consumed_o))
  `TCW_ASSERT(a_unconsumed_closes, !empty && !byte_consumed_o, !escape_open_o)
  `TCW_ASSERT(a_unconsumed_nodata, !empty && !byte_consumed_o, read_data_o == 16'h0000)
  `TCW_ASSERT(a_cursor_range, !empty && (Cells <= 2048), {21'b0, cursor_index_o} < Cells)

endmodule

bind text_console_writer_with_sgr tcw_checker #(
  .SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
  .clk_i, .rst_ni, .empty, .pop, .read_data_o, .cursor_index_o, .byte_consumed_o,
  .escape_open_o
);
`default_nettype wire
